// ===== design/closable_ring_fifo_unit_macros.svh =====
// Assertion helpers used by closable_ring_fifo_unit
`ifndef CLOSABLE_RING_FIFO_UNIT_MACROS_SVH
`define CLOSABLE_RING_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define CRF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("closable ring fifo: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define CRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("closable ring fifo: next-cycle check failed");

`endif

// ===== design/crf_pkg.sv =====
package crf_pkg;

	// Fixed field widths
	localparam int ACT_W  = 2;
	localparam int DATA_W = 32;
	localparam int FILL_W = 5;
	localparam int STAT_W = 2;

	// Defaults for the top-level parameters
	localparam int DEF_DEPTH = 16;
	localparam int DEF_WIDTH = 32;

	// Depth limit after reset
	localparam logic [FILL_W-1:0] LIMIT_RST = 5'd16;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RECV  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_CLOSED = 2'd3;

	// One result beat, status in the lowest bits
	typedef struct packed {
		logic              is_closed;
		logic [FILL_W-1:0] fill_count;
		logic [DATA_W-1:0] data_out;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

// ===== design/closable_ring_fifo_unit.sv =====
// Closable ring-buffer FIFO. Each input beat carries an action in s_tuser (send, receive or
// close) and a value in s_tdata; each beat gives exactly one result beat with status, popped
// value (zero unless a receive succeeded), fill count and closed flag. One beat is taken per
// clock while the first stage can move on. An accepted beat updates the pointers and launches
// the single registered read of the storage RAM, then the output register is loaded; a
// two-entry output stage keeps the input moving while a result waits. cfg_data sets the depth
// limit (0 acts as 1, above DEPTH acts as DEPTH, reset 16); the user must write it only while
// the block is idle; the block does not enforce this. Storage is not cleared: there is no
// start-up pass, only written slots are ever read, and slots wrap modulo DEPTH for any limit.
`include "closable_ring_fifo_unit_macros.svh"

module closable_ring_fifo_unit #(
	parameter int DEPTH = crf_pkg::DEF_DEPTH,
	parameter int WIDTH = crf_pkg::DEF_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: depth_limit
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crf_pkg::FILL_W-1:0]  cfg_data,
	// input beats
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [crf_pkg::DATA_W-1:0]  s_tdata,  // [31:0] data_in
	input  logic [crf_pkg::ACT_W-1:0]   s_tuser,  // [1:0] action
	// result beats
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata   // [1:0] status, [33:2] data_out,
	                                              // [38:34] fill_count, [39] is_closed
);

	import crf_pkg::*;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int SUM_W   = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
	localparam int LIM_MAX = (DEPTH < 31) ? DEPTH : 31;

	// Architectural state
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] held_q;
	logic              closed_q;
	logic [FILL_W-1:0] limit_q;

	// First stage
	logic              valid_s1;
	logic [STAT_W-1:0] status_s1;
	logic              pop_s1;
	logic [FILL_W-1:0] fill_s1;
	logic              closed_s1;

	logic              accept;
	logic              s1_move;
	logic              skid_ready;
	logic [FILL_W-1:0] lim_eff;
	logic [STAT_W-1:0] status_d;
	logic              push;
	logic              pop;
	logic              closed_d;
	logic [FILL_W-1:0] held_d;
	logic [SUM_W-1:0]  wr_sum;
	logic [SUM_W-1:0]  wr_wrap;
	logic [PTR_W-1:0]  wr_addr;
	logic [PTR_W-1:0]  rd_next;
	logic [WIDTH-1:0]  wr_data;
	logic [WIDTH-1:0]  rd_data;
	result_t           res_s1;
	result_t           res_out;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign s1_move   = valid_s1 && skid_ready;
	assign s_tready  = !valid_s1 || skid_ready;

	// Clamp the depth limit to 1..min(DEPTH, 31)
	always_comb begin
		if (limit_q == '0) begin
			lim_eff = FILL_W'(1);
		end else if (limit_q > FILL_W'(LIM_MAX)) begin
			lim_eff = FILL_W'(LIM_MAX);
		end else begin
			lim_eff = limit_q;
		end
	end

	// Decode the action against the current state
	always_comb begin
		status_d = ST_OK;
		push     = 1'b0;
		pop      = 1'b0;
		closed_d = closed_q;
		unique case (s_tuser)
			ACT_SEND: begin
				if (closed_q) begin
					status_d = ST_CLOSED;
				end else if (held_q >= lim_eff) begin
					status_d = ST_FULL;
				end else begin
					push = 1'b1;
				end
			end
			ACT_RECV: begin
				if (held_q != '0) begin
					pop = 1'b1;
				end else begin
					status_d = closed_q ? ST_CLOSED : ST_EMPTY;
				end
			end
			ACT_CLOSE: begin
				if (closed_q) begin
					status_d = ST_CLOSED;
				end
				closed_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Advance the fill count
	always_comb begin
		if (push) begin
			held_d = held_q + FILL_W'(1);
		end else if (pop) begin
			held_d = held_q - FILL_W'(1);
		end else begin
			held_d = held_q;
		end
	end

	// Slot behind the newest value, wrapped modulo DEPTH
	assign wr_sum  = SUM_W'(rd_ptr_q) + SUM_W'(held_q);
	assign wr_wrap = (wr_sum >= SUM_W'(DEPTH)) ? (wr_sum - SUM_W'(DEPTH)) : wr_sum;
	assign wr_addr = wr_wrap[PTR_W-1:0];
	assign rd_next = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_q + PTR_W'(1));
	assign wr_data = WIDTH'(s_tdata);

	// State update on each accepted beat and each configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			held_q   <= '0;
			closed_q <= 1'b0;
			limit_q  <= LIMIT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				held_q   <= held_d;
				closed_q <= closed_d;
				if (pop) begin
					rd_ptr_q <= rd_next;
				end
			end
		end
	end

	// First-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// First-stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			pop_s1    <= pop;
			fill_s1   <= held_d;
			closed_s1 <= closed_d;
		end
	end

	crf_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && push),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept && pop),
		.raddr (rd_ptr_q),
		.rdata (rd_data)
	);

	// Assemble the result; popped value is zero unless a receive succeeded
	always_comb begin
		res_s1.status     = status_s1;
		res_s1.data_out   = pop_s1 ? DATA_W'(rd_data) : '0;
		res_s1.fill_count = fill_s1;
		res_s1.is_closed  = closed_s1;
	end

	crf_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (skid_ready),
		.in_res    (res_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res_out)
	);

	assign m_tdata = res_out;

	// Checks
	`CRF_ASSERT_NOW(a_fill_bound, 1'b1, held_q <= FILL_W'(LIM_MAX))
	`CRF_ASSERT_NEXT(a_closed_sticks, closed_q, closed_q)
	`CRF_ASSERT_NEXT(a_rdata_held, valid_s1 && pop_s1 && !s1_move, $stable(rd_data))
	`CRF_ASSERT_NEXT(a_push_counts, accept && push, held_q == $past(held_q) + FILL_W'(1))
	`CRF_ASSERT_NOW(a_push_pop_excl, accept, !(push && pop))

endmodule

// ===== design/crf_ram.sv =====
module crf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/crf_skid.sv =====
module crf_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  crf_pkg::result_t in_res,
	output logic             out_valid,
	input  logic             out_ready,
	output crf_pkg::result_t out_res
);

	import crf_pkg::*;

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    load_main;

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;
	assign load_main = !main_v_q || out_ready;

	// Control: refill the output register from the skid entry first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_main) begin
			main_v_q <= skid_v_q || in_valid;
			skid_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load_main) begin
			main_q <= skid_v_q ? skid_q : in_res;
		end else if (in_valid && in_ready) begin
			skid_q <= in_res;
		end
	end

endmodule

// ===== test/crf_reply_checker.sv =====
module crf_reply_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [crf_pkg::FILL_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [crf_pkg::DATA_W-1:0] s_tdata,  // [31:0] data_in
	input  logic [crf_pkg::ACT_W-1:0]  s_tuser,  // [1:0] action
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [39:0]                m_tdata,  // [1:0] status, [33:2] data_out,
	                                             // [38:34] fill_count, [39] is_closed
	output int                         fail_count,
	output int                         outstanding
);
	import crf_pkg::*;

	localparam int SLOTS = DEF_DEPTH;
	localparam int IDX_W = $clog2(SLOTS);

	// Mirror of the queue and its depth limit
	logic [DATA_W-1:0] slot_mem [SLOTS];
	logic [IDX_W-1:0]  oldest_pos;
	logic [FILL_W-1:0] held_cnt;
	logic              shut;
	logic [FILL_W-1:0] depth_lim;

	// Replies owed by the block, oldest first
	result_t owed_replies [$];

	// Apply one action to the mirror and work out the reply it earns
	function automatic result_t predict_reply(logic [ACT_W-1:0] act, logic [DATA_W-1:0] din);
		result_t           r;
		logic [FILL_W-1:0] lim;
		r = '0;
		r.status = ST_OK;
		if (depth_lim == '0)
			lim = FILL_W'(1);
		else if (depth_lim > FILL_W'(SLOTS))
			lim = FILL_W'(SLOTS);
		else
			lim = depth_lim;
		case (act)
			ACT_SEND: begin
				if (shut)
					r.status = ST_CLOSED;
				else if (held_cnt >= lim)
					r.status = ST_FULL;
				else begin
					slot_mem[IDX_W'((int'(oldest_pos) + int'(held_cnt)) % SLOTS)] = din;
					held_cnt = held_cnt + FILL_W'(1);
				end
			end
			ACT_RECV: begin
				if (held_cnt != '0) begin
					r.data_out = slot_mem[oldest_pos];
					oldest_pos = IDX_W'((int'(oldest_pos) + 1) % SLOTS);
					held_cnt = held_cnt - FILL_W'(1);
				end else begin
					r.status = shut ? ST_CLOSED : ST_EMPTY;
				end
			end
			ACT_CLOSE: begin
				if (shut)
					r.status = ST_CLOSED;
				shut = 1'b1;
			end
			default: begin
				// spare code: leave everything as it is
			end
		endcase
		r.fill_count = held_cnt;
		r.is_closed = shut;
		return r;
	endfunction

	// Watch all three channels on the same edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		int      bad;
		int      delta;
		if (!arst_n) begin
			oldest_pos = '0;
			held_cnt = '0;
			shut = 1'b0;
			depth_lim = LIMIT_RST;
			owed_replies.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			delta = 0;
			if (cfg_valid && cfg_ready)
				depth_lim = cfg_data;
			// compare each result beat with the oldest owed reply
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				delta = delta - 1;
				if (owed_replies.size() == 0) begin
					$error("result beat with no reply owed: %h", m_tdata);
					bad++;
				end else begin
					want = owed_replies.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						bad++;
					end
					if (got.data_out !== want.data_out) begin
						$error("data_out: expected %h, got %h", want.data_out, got.data_out);
						bad++;
					end
					if (got.fill_count !== want.fill_count) begin
						$error("fill_count: expected %0d, got %0d", want.fill_count,
							got.fill_count);
						bad++;
					end
					if (got.is_closed !== want.is_closed) begin
						$error("is_closed: expected %0d, got %0d", want.is_closed,
							got.is_closed);
						bad++;
					end
				end
			end
			// predict the reply for each accepted action beat
			if (s_tvalid && s_tready) begin
				owed_replies.push_back(predict_reply(s_tuser, s_tdata));
				delta = delta + 1;
			end
			fail_count <= fail_count + bad;
			outstanding <= outstanding + delta;
		end
	end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import crf_pkg::*;

	// Action code the block leaves unused
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [FILL_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0]  s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [39:0]       m_tdata;
	int                fail_count;
	int                outstanding;

	// Traffic shaping knobs
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	logic rx_hold = 1'b0;

	closable_ring_fifo_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	crf_reply_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// Stall the result side at random, or hold it off entirely on request
	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Offer one action beat after optional idle cycles and wait until it is taken
	task automatic push_action(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
	endtask

	// Let the queue drain, then write the depth limit
	task automatic write_limit(input logic [FILL_W-1:0] lim);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Bursts of sends and receives, with spare codes and optional closes, in a drifting mix, so the fill swings end to end
	task automatic run_random(input int count, input bit with_close);
		int               send_pct;
		int               burst_left;
		int               roll;
		logic [ACT_W-1:0] act;
		logic [DATA_W-1:0] val;
		send_pct = 50;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				case ($urandom_range(2))
					0: send_pct = 15;
					1: send_pct = 50;
					default: send_pct = 85;
				endcase
				burst_left = $urandom_range(40, 8);
			end
			burst_left--;
			roll = $urandom_range(99);
			if (roll < 3)
				act = ACT_SPARE;
			else if (with_close && roll < 6)
				act = ACT_CLOSE;
			else if ($urandom_range(99) < send_pct)
				act = ACT_SEND;
			else
				act = ACT_RECV;
			case ($urandom_range(9))
				0: val = '0;
				1: val = '1;
				default: val = $urandom();
			endcase
			push_action(act, val);
		end
	endtask

	initial begin
		logic [FILL_W-1:0] phase_lims [8];
		int                idle_mix [4];
		int                stall_mix [4];
		phase_lims = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd8, 5'd17, 5'd3, 5'd31};
		idle_mix = '{0, 84, 0, 33};
		stall_mix = '{0, 0, 84, 33};

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty receive, spare code, data extremes, drain past empty
		push_action(ACT_RECV, 32'h0);
		push_action(ACT_SPARE, 32'hFFFF_FFFF);
		push_action(ACT_SEND, 32'h0000_0000);
		push_action(ACT_SEND, 32'hFFFF_FFFF);
		push_action(ACT_SEND, 32'hAAAA_AAAA);
		push_action(ACT_SEND, 32'h5555_5555);
		repeat (5) push_action(ACT_RECV, 32'h0);

		// Zero limit behaves as one
		write_limit(5'd0);
		push_action(ACT_SEND, 32'h0000_0001);
		push_action(ACT_SEND, 32'h0000_0002);
		push_action(ACT_SPARE, 32'h0);
		push_action(ACT_RECV, 32'h0);
		push_action(ACT_RECV, 32'h0);

		// Lower the limit beneath the current fill
		write_limit(5'd16);
		push_action(ACT_SEND, 32'h1234_5678);
		push_action(ACT_SEND, 32'h8765_4321);
		push_action(ACT_SEND, 32'hDEAD_BEEF);
		write_limit(5'd2);
		push_action(ACT_SEND, 32'h0BAD_F00D);
		push_action(ACT_RECV, 32'h0);
		push_action(ACT_SEND, 32'h0BAD_F00D);
		push_action(ACT_RECV, 32'h0);
		push_action(ACT_SEND, 32'hCAFE_0001);

		// Random phases over every traffic mix and a spread of limits
		for (int p = 0; p < 8; p++) begin
			write_limit(phase_lims[p]);
			tx_idle_pct = idle_mix[p % 4];
			rx_stall_pct <= stall_mix[p % 4];
			run_random(140, 1'b0);
		end

		// Back-pressure: hold the result side off while sends keep coming
		write_limit(5'd16);
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
			begin
				for (int i = 0; i < 60; i++)
					push_action(($urandom_range(9) == 0) ? ACT_RECV : ACT_SEND, $urandom());
			end
		join

		// Closing: values held, close twice, send refused, drain into closed-empty
		write_limit(5'd31);
		tx_idle_pct = 33;
		rx_stall_pct <= 33;
		push_action(ACT_SEND, 32'hFEED_0001);
		push_action(ACT_SEND, 32'hFEED_0002);
		push_action(ACT_CLOSE, 32'h0);
		push_action(ACT_CLOSE, 32'hFFFF_FFFF);
		push_action(ACT_SEND, 32'hFEED_0003);
		repeat (3) push_action(ACT_RECV, 32'h0);
		run_random(100, 1'b1);

		// Drain and give the verdict
		s_tvalid <= 1'b0;
		rx_stall_pct <= 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
